@@ rtl/rwfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rwfr_pkg
// Shared types and constants of the register write frame receiver.
// ----------------------------------------------------------------------------
package rwfr_pkg;

  localparam int unsigned BUFFER_DEPTH    = 32;
  localparam int unsigned REGISTER_COUNT  = 16;
  localparam int unsigned MIN_FRAME_BYTES = 2;

  // frame length counts up to BUFFER_DEPTH inclusive
  localparam int unsigned LEN_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REG_W  = 9;
  localparam int unsigned CNT_W  = 32;

  // func codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_STOP = 1'b1;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [REG_W-1:0]  target_register;
    logic [BYTE_W-1:0] write_value;
    logic              applied;
    logic              last_of_frame;
    logic [CNT_W-1:0]  frames_seen;
    logic [CNT_W-1:0]  overflow_total;
    logic [CNT_W-1:0]  discard_total;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/rwfr_frame_mem.sv @@
// ----------------------------------------------------------------------------
// rwfr_frame_mem
// Frame byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rwfr_frame_mem import rwfr_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0] mem_q [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/register_write_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// register_write_frame_receiver_top
// Buffers the bytes of a bus write frame and turns them into register writes
// when the stop arrives.
// ----------------------------------------------------------------------------
// A data byte is taken and stored in the frame buffer memory; bytes can
// arrive back to back. A stop is taken, then the start register is read from
// buffer entry 0 (the memory has registered read data), and after that one
// write result leaves per cycle while the output is taken, each read of the
// next byte overlapping the current transfer. A frame of N bytes (N >= 2)
// therefore holds the input off until its last result is registered, longer
// under output stalls; a short frame gives its single result from S_EMPTY
// once the output register is free. The output register lets a new frame's
// bytes come in while the last result still waits.
// ----------------------------------------------------------------------------
module register_write_frame_receiver_top import rwfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_WAIT_START = 3'd1;
  localparam logic [2:0] S_EMIT       = 3'd2;
  localparam logic [2:0] S_EMPTY      = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] start_q, start_d;
  logic [CNT_W-1:0]  frame_cnt_q, frame_cnt_d;
  logic [CNT_W-1:0]  ovf_cnt_q, ovf_cnt_d;
  logic [CNT_W-1:0]  disc_cnt_q, disc_cnt_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rd_data;

  logic              in_xfer;
  logic              slot_free;
  logic [REG_W-1:0]  tgt_addr;
  logic              in_range;
  logic              is_last;
  logic [CNT_W-1:0]  disc_next;

  rwfr_frame_mem u_frame_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // byte at idx_q writes to start + idx_q - 1
  assign tgt_addr  = REG_W'(start_q) + REG_W'(idx_q) - REG_W'(1);
  assign in_range  = (tgt_addr < REG_W'(REGISTER_COUNT));
  assign is_last   = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
  assign disc_next = in_range ? disc_cnt_q : disc_cnt_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    start_d     = start_q;
    frame_cnt_d = frame_cnt_q;
    ovf_cnt_d   = ovf_cnt_q;
    disc_cnt_d  = disc_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    mem_req       = '0;
    mem_req.waddr = len_q[ADDR_W-1:0];
    mem_req.wdata = in_data_i.rx_byte;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.func == FUNC_BYTE) begin
            if (len_q < LEN_W'(BUFFER_DEPTH)) begin
              mem_req.we = 1'b1;
              len_d      = len_q + LEN_W'(1);
            end else begin
              ovf_cnt_d = ovf_cnt_q + CNT_W'(1);
            end
          end else begin
            frame_cnt_d = frame_cnt_q + CNT_W'(1);
            if (len_q < LEN_W'(MIN_FRAME_BYTES)) begin
              len_d   = '0;
              state_d = S_EMPTY;
            end else begin
              // fetch the start register byte
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_d       = S_WAIT_START;
            end
          end
        end
      end
      S_WAIT_START: begin
        start_d       = rd_data;
        mem_req.re    = 1'b1;
        mem_req.raddr = ADDR_W'(1);
        idx_d         = ADDR_W'(1);
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d                 = 1'b1;
          out_d.write_enable          = in_range;
          out_d.target_register       = tgt_addr;
          out_d.write_value           = rd_data;
          out_d.applied               = 1'b1;
          out_d.last_of_frame         = is_last;
          out_d.frames_seen           = frame_cnt_q;
          out_d.overflow_total        = ovf_cnt_q;
          out_d.discard_total         = disc_next;
          disc_cnt_d                  = disc_next;
          if (is_last) begin
            len_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d         = idx_q + ADDR_W'(1);
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_q + ADDR_W'(1);
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_d.write_enable    = 1'b0;
          out_d.target_register = '0;
          out_d.write_value     = '0;
          out_d.applied         = 1'b0;
          out_d.last_of_frame   = 1'b1;
          out_d.frames_seen     = frame_cnt_q;
          out_d.overflow_total  = ovf_cnt_q;
          out_d.discard_total   = disc_cnt_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      frame_cnt_q <= '0;
      ovf_cnt_q   <= '0;
      disc_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      frame_cnt_q <= frame_cnt_d;
      ovf_cnt_q   <= ovf_cnt_d;
      disc_cnt_q  <= disc_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    start_q <= start_d;
    out_q   <= out_d;
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks register_write_frame_receiver_top against a cycle-free predictor of
// the frame buffer. It sends bus frames (start register byte, data bytes,
// stop), checks every register write result field by field, and randomly
// throttles both valid/ready channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rwfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef struct packed {
    logic     drain_wait;  // marker: hold the sender until all writes are back
    in_item_t item;
  } bus_slot_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  bus_slot_t bus_items[$];
  out_item_t expected_writes[$];

  // predictor state
  logic [BYTE_W-1:0] frame_bytes [BUFFER_DEPTH];
  int unsigned       frame_len = 0;
  logic [CNT_W-1:0]  stop_count = '0;
  logic [CNT_W-1:0]  dropped_bytes = '0;
  logic [CNT_W-1:0]  discarded_writes = '0;

  logic        in_took = 1'b0;
  int unsigned items_taken = 0;
  int unsigned writes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // sender burst / gap state
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // receiver stall state
  int unsigned rx_tick = 0;
  int unsigned hold_left = 0;
  logic        long_hold_done = 1'b0;

  register_write_frame_receiver_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycles,
               expected_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic predict_frame_writes(input in_item_t it);
    out_item_t        w;
    logic [REG_W-1:0] addr;
    if (it.func == FUNC_BYTE) begin
      if (frame_len < BUFFER_DEPTH) begin
        frame_bytes[frame_len] = it.rx_byte;
        frame_len++;
      end else begin
        dropped_bytes++;
      end
    end else begin
      stop_count++;
      if (frame_len < MIN_FRAME_BYTES) begin
        w = '0;
        w.last_of_frame  = 1'b1;
        w.frames_seen    = stop_count;
        w.overflow_total = dropped_bytes;
        w.discard_total  = discarded_writes;
        expected_writes.push_back(w);
      end else begin
        for (int unsigned i = 1; i < frame_len; i++) begin
          addr = REG_W'(frame_bytes[0]) + REG_W'(i - 1);
          w.write_enable = (addr < REGISTER_COUNT);
          if (!w.write_enable) discarded_writes++;
          w.target_register = addr;
          w.write_value     = frame_bytes[i];
          w.applied         = 1'b1;
          w.last_of_frame   = (i + 1 == frame_len);
          w.frames_seen     = stop_count;
          w.overflow_total  = dropped_bytes;
          w.discard_total   = discarded_writes;
          expected_writes.push_back(w);
        end
      end
      frame_len = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin : monitor
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $error("write result with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        e = expected_writes.pop_front();
        check_field("write_enable", CNT_W'(e.write_enable),
                    CNT_W'(out_data.write_enable));
        check_field("target_register", CNT_W'(e.target_register),
                    CNT_W'(out_data.target_register));
        check_field("write_value", CNT_W'(e.write_value), CNT_W'(out_data.write_value));
        check_field("applied", CNT_W'(e.applied), CNT_W'(out_data.applied));
        check_field("last_of_frame", CNT_W'(e.last_of_frame),
                    CNT_W'(out_data.last_of_frame));
        check_field("frames_seen", e.frames_seen, out_data.frames_seen);
        check_field("overflow_total", e.overflow_total, out_data.overflow_total);
        check_field("discard_total", e.discard_total, out_data.discard_total);
      end
      writes_checked++;
    end
    if (rst_n && in_valid && in_ready) begin
      predict_frame_writes(in_data);
      items_taken++;
    end
    in_took <= rst_n && in_valid && in_ready;
  end

  // ------------------------------------------------------------------- driver
  always @(negedge clk) begin : driver
    logic      v_next;
    in_item_t  d_next;
    bus_slot_t s_next;
    v_next = in_valid;
    d_next = in_data;
    if (rst_n) begin
      if (in_took) v_next = 1'b0;
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (bus_items.size() != 0) begin
          if (bus_items[0].drain_wait) begin
            if (expected_writes.size() == 0) void'(bus_items.pop_front());
          end else begin
            s_next = bus_items.pop_front();
            d_next = s_next.item;
            v_next = 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
          end
        end
      end
    end
    in_valid <= v_next;
    in_data  <= d_next;
  end

  // receiver: rotating stall patterns plus one long hold-off
  always @(negedge clk) begin : receiver
    logic r_next;
    r_next = 1'b1;
    if (rst_n) begin
      rx_tick++;
      if (!long_hold_done && writes_checked >= 30) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        r_next = 1'b0;
      end else begin
        case ((rx_tick / 97) % 3)
          0: r_next = 1'b1;
          1: r_next = 1'($urandom_range(0, 1));
          default: r_next = (rx_tick % 4 == 0);
        endcase
      end
    end else begin
      r_next = 1'b0;
    end
    out_ready <= r_next;
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    bus_slot_t s;
    s.drain_wait   = 1'b0;
    s.item.func    = FUNC_BYTE;
    s.item.rx_byte = b;
    bus_items.push_back(s);
  endtask

  task automatic push_stop(input logic [BYTE_W-1:0] junk);
    bus_slot_t s;
    s.drain_wait   = 1'b0;
    s.item.func    = FUNC_STOP;
    s.item.rx_byte = junk;  // ignored by the block
    bus_items.push_back(s);
  endtask

  task automatic push_frame(input logic [BYTE_W-1:0] base_reg, input int unsigned n_data);
    push_byte(base_reg);
    repeat (n_data) push_byte(BYTE_W'($urandom_range(0, 255)));
    push_stop(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic push_drain();
    bus_slot_t s;
    s = '0;
    s.drain_wait = 1'b1;
    bus_items.push_back(s);
  endtask

  initial begin : main
    int unsigned       n_queued;
    int unsigned       kind;
    logic [BYTE_W-1:0] base_reg;
    logic              drained_mid;

    // directed: empty and one-byte frames, data extremes, range edges
    push_stop(8'hFF);
    push_byte(8'h00);
    push_stop(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_stop(8'h55);
    push_byte(8'd14);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_stop(8'hAA);
    push_byte(8'd15);
    push_byte(8'h5A);
    push_stop(8'h0F);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_stop(8'hF0);
    push_drain();

    // random part: a full frame that overflows to reach the top address,
    // then mostly well-formed frames with some broken ones mixed in
    n_queued = 0;
    drained_mid = 1'b0;
    push_frame(8'hFF, 33);
    n_queued += 35;
    while (n_queued < 112) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        if ($urandom_range(0, 1)) begin
          push_byte(BYTE_W'($urandom_range(0, 255)));
          n_queued++;
        end
        push_stop(BYTE_W'($urandom_range(0, 255)));
        n_queued++;
      end else if (kind == 1) begin
        base_reg = BYTE_W'($urandom_range(0, 255));
        kind = $urandom_range(28, 40);
        push_frame(base_reg, kind);
        n_queued += kind + 2;
      end else begin
        base_reg = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                : BYTE_W'($urandom_range(0, 17));
        kind = $urandom_range(1, 8);
        push_frame(base_reg, kind);
        n_queued += kind + 2;
      end
      if (!drained_mid && n_queued >= 70) begin
        drained_mid = 1'b1;
        push_drain();
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bus_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d bus items in %0d frames; checked %0d write results", items_taken,
             stop_count, writes_checked);
    $display("buffer overflows: %0d bytes, out-of-range writes: %0d", dropped_bytes,
             discarded_writes);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
